// ===== sv/txdc_pkg.sv =====
// shared types and constants of the doppler correction block
package txdc_pkg;

  localparam int XS_W       = 48;
  localparam int E_W        = 64;
  localparam int T_W        = 64;
  localparam int AW_W       = 32;
  localparam int TV_W       = 32;
  localparam int TI_W       = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  typedef enum logic {
    CMD_CORRECT = 1'b0,
    CMD_LOAD    = 1'b1
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] REG_OLD_TEMP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEW_TEMP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATOM_WEIGHT = 2'd2;

  typedef struct packed {
    cmd_t            cmd;
    logic [TI_W-1:0] table_index;
    logic [TV_W-1:0] table_value;
    logic [E_W-1:0]  energy;
    logic [XS_W-1:0] total_xs;
    logic [XS_W-1:0] elastic_xs;
  } point_t;

  typedef struct packed {
    logic [XS_W-1:0] total_xs_out;
    logic [XS_W-1:0] elastic_xs_out;
    logic            adjusted;
  } result_t;

  // item fields that ride along the arithmetic pipeline
  typedef struct packed {
    cmd_t            cmd;
    logic [TI_W-1:0] idx;
    logic [TV_W-1:0] tval;
    logic [XS_W-1:0] tot;
    logic [XS_W-1:0] el;
    logic            pass;
  } carry_t;

endpackage

// ===== sv/txdc_stream_if.sv =====
// valid/ready stream channel
interface txdc_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/txdc_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with side data
module txdc_div #(
  parameter int NW = 128,
  parameter int DW = 96,
  parameter int QW = 64,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vin,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          vout,
  output logic [QW-1:0] quo,
  output logic [SW-1:0] side_out
);

  logic [DW-1:0] rem_r  [QW];
  logic [QW-1:0] low_r  [QW];
  logic [QW-1:0] quo_r  [QW];
  logic [DW-1:0] den_r  [QW];
  logic [SW-1:0] side_r [QW];
  logic          vld_r  [QW];

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [DW-1:0] rem_in;
    logic [QW-1:0] low_in;
    logic [QW-1:0] quo_in;
    logic [DW-1:0] den_in;
    logic [SW-1:0] side_s;
    logic          vld_in;
    logic [DW:0]   trial;
    logic [DW:0]   delta;
    logic          take;

    if (i == 0) begin : g_first
      // quotient fits QW bits, so the upper numerator part is below den
      assign rem_in = DW'(num[NW-1:QW]);
      assign low_in = num[QW-1:0];
      assign quo_in = '0;
      assign den_in = den;
      assign side_s = side_in;
      assign vld_in = vin;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign low_in = low_r[i-1];
      assign quo_in = quo_r[i-1];
      assign den_in = den_r[i-1];
      assign side_s = side_r[i-1];
      assign vld_in = vld_r[i-1];
    end

    assign trial = {rem_in, low_in[QW-1]};
    assign take  = trial >= {1'b0, den_in};
    assign delta = trial - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= take ? delta[DW-1:0] : trial[DW-1:0];
        low_r[i]  <= low_in << 1;
        quo_r[i]  <= QW'({quo_in, take});
        den_r[i]  <= den_in;
        side_r[i] <= side_s;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end
  end

  assign vout     = vld_r[QW-1];
  assign quo      = quo_r[QW-1];
  assign side_out = side_r[QW-1];

endmodule

// ===== sv/txdc_sqrt.sv =====
// pipelined integer square root, one root bit per stage, with side data
module txdc_sqrt #(
  parameter int RW = 31,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            vin,
  input  logic [2*RW-1:0] x,
  input  logic [SW-1:0]   side_in,
  output logic            vout,
  output logic [RW-1:0]   root,
  output logic [SW-1:0]   side_out
);

  localparam int XW   = 2 * RW;
  localparam int REMW = RW + 3;

  logic [REMW-1:0] rem_r  [RW];
  logic [RW-1:0]   root_r [RW];
  logic [XW-1:0]   x_r    [RW];
  logic [SW-1:0]   side_r [RW];
  logic            vld_r  [RW];

  for (genvar i = 0; i < RW; i++) begin : g_step
    logic [REMW-1:0] rem_in;
    logic [RW-1:0]   root_in;
    logic [XW-1:0]   x_in;
    logic [SW-1:0]   side_s;
    logic            vld_in;
    logic [REMW-1:0] cat;
    logic [REMW-1:0] trial;
    logic            take;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = x;
      assign side_s  = side_in;
      assign vld_in  = vin;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign x_in    = x_r[i-1];
      assign side_s  = side_r[i-1];
      assign vld_in  = vld_r[i-1];
    end

    // bring down the next bit pair and try root*4+1
    assign cat   = REMW'({rem_in, x_in[XW-1 -: 2]});
    assign trial = REMW'({root_in, 2'b01});
    assign take  = cat >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= take ? cat - trial : cat;
        root_r[i] <= RW'({root_in, take});
        x_r[i]    <= x_in << 2;
        side_r[i] <= side_s;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end
  end

  assign vout     = vld_r[RW-1];
  assign root     = root_r[RW-1];
  assign side_out = side_r[RW-1];

endmodule

// ===== sv/txdc_table.sv =====
// thermal table in even and odd banks, two lanes each read one interval
module txdc_table #(
  parameter int ENTRIES = 51
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic                      we,
  input  logic [txdc_pkg::TI_W-1:0] waddr,
  input  logic [txdc_pkg::TV_W-1:0] wdata,
  input  logic [txdc_pkg::TI_W-1:0] ridx0,
  input  logic [txdc_pkg::TI_W-1:0] ridx1,
  output logic [txdc_pkg::TV_W-1:0] lo0,
  output logic [txdc_pkg::TV_W-1:0] hi0,
  output logic [txdc_pkg::TV_W-1:0] lo1,
  output logic [txdc_pkg::TV_W-1:0] hi1
);

  localparam int EV  = (ENTRIES + 1) / 2;
  localparam int OD  = ENTRIES / 2;
  localparam int EAW = (EV > 1) ? $clog2(EV) : 1;
  localparam int OAW = (OD > 1) ? $clog2(OD) : 1;
  localparam int TIW = txdc_pkg::TI_W;

  logic [txdc_pkg::TV_W-1:0] ev_mem [EV];
  logic [txdc_pkg::TV_W-1:0] od_mem [OD];
  logic [txdc_pkg::TV_W-1:0] ev_d0, ev_d1, od_d0, od_d1;
  logic                      odd0, odd1;
  logic [EAW-1:0]            ev_a0, ev_a1;
  logic [OAW-1:0]            od_a0, od_a1;

  // entry idx and idx+1 always sit in opposite banks
  assign ev_a0 = EAW'(((TIW+1)'(ridx0) + (TIW+1)'(1)) >> 1);
  assign ev_a1 = EAW'(((TIW+1)'(ridx1) + (TIW+1)'(1)) >> 1);
  assign od_a0 = OAW'(ridx0 >> 1);
  assign od_a1 = OAW'(ridx1 >> 1);

  always_ff @(posedge clk) begin
    if (we && (32'(waddr) < ENTRIES)) begin
      if (waddr[0]) begin
        od_mem[OAW'(waddr >> 1)] <= wdata;
      end else begin
        ev_mem[EAW'(waddr >> 1)] <= wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ev_d0 <= ev_mem[ev_a0];
      ev_d1 <= ev_mem[ev_a1];
      od_d0 <= od_mem[od_a0];
      od_d1 <= od_mem[od_a1];
      odd0  <= ridx0[0];
      odd1  <= ridx1[0];
    end
  end

  assign lo0 = odd0 ? od_d0 : ev_d0;
  assign hi0 = odd0 ? ev_d0 : od_d0;
  assign lo1 = odd1 ? od_d1 : ev_d1;
  assign hi1 = odd1 ? ev_d1 : od_d1;

endmodule

// ===== sv/thermal_xs_doppler_correction.sv =====
// top level of the free-gas doppler correction pipeline
//
// channels: points (sink) carries grid points and table loads, results
// (source) carries one corrected point for each grid point, in order.
// a load item writes one thermal table entry and yields no result.
// configuration: cfg_we/cfg_index/cfg_data write old_temp, new_temp and
// atom_weight; write them only while no item is in flight.
// throughput: one item per cycle while the pipeline is not stalled. a grid
// point reaches results through four bit-per-stage units in series: a
// 64-stage divider for a^2 or the high-energy factor, a 31-stage square
// root, a 66-stage divider for G/a and a 50-stage divider for the
// correction, plus the plain stages s0-s3, t1-t4, f, c1-c4, m and output.
// the table sits in two banks with registered reads, read in the stage
// where loads also write, so loads and reads stay in item order.
// reset clears the valid bits of every stage and the registers to 0, 0
// and atom_weight 1.0; table contents are undefined until loaded.
// stall: the whole pipeline holds while a result waits and results.ready
// is low; points.ready follows the same advance signal.
module thermal_xs_doppler_correction #(
  parameter int TABLE_ENTRIES = 51
) (
  input  logic                                 clk,
  input  logic                                 rst,
  txdc_stream_if.sink                          points,
  txdc_stream_if.source                        results,
  input  logic                                 cfg_we,
  input  logic [txdc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [txdc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int XS_W = txdc_pkg::XS_W;
  localparam int TV_W = txdc_pkg::TV_W;
  localparam int TI_W = txdc_pkg::TI_W;

  typedef struct packed {
    txdc_pkg::carry_t c;
    logic             big_o;
    logic             tz_o;
  } d1a_t;

  typedef struct packed {
    logic big_n;
    logic tz_n;
  } d1b_t;

  typedef struct packed {
    txdc_pkg::carry_t c;
    logic [63:0]      fpre_o;
    logic             sel_o;
  } lane_a_t;

  typedef struct packed {
    logic [63:0] fpre_n;
    logic        sel_n;
  } lane_b_t;

  typedef struct packed {
    txdc_pkg::carry_t c;
    logic             up;
    logic             clamp;
    logic             fz;
  } d3_t;

  // configuration and values derived from it
  logic [63:0] old_temp, new_temp;
  logic [31:0] atom_weight;
  logic [63:0] temp_diff;
  logic        skip_all;
  logic [72:0] cutoff;

  logic adv;

  // front stages
  logic              v0, v1, v2, v3;
  txdc_pkg::point_t  pt0, pt1, pt2;
  logic [63:0]       p_hi1, p_lo1;
  logic [95:0]       num2;
  logic              big_o, big_n;
  logic [127:0]      dn3_o, dn3_n;
  logic [95:0]       dd3_o, dd3_n;
  d1a_t              d1a_in, d1a_out;
  d1b_t              d1b_in, d1b_out;
  logic              vd_a, vd_b;
  logic [63:0]       qd_o, qd_n;

  // square root and interpolation
  lane_a_t           sqa_in, sqa_out;
  lane_b_t           sqb_in, sqb_out;
  logic              vs_a, vs_b;
  logic [30:0]       root_o, root_n;
  logic [30:0]       af_o, af_n;
  logic [35:0]       sc_o, sc_n;
  logic [TI_W-1:0]   ix_o, ix_n;

  logic              v_t1, v_t2, v_t3, v_t4;
  lane_a_t           la_t1, la_t2, la_t3, la_t4;
  lane_b_t           lb_t1, lb_t2, lb_t3, lb_t4;
  logic [30:0]       a_t1_o, a_t1_n, a_t2_o, a_t2_n, a_t3_o, a_t3_n, a_t4_o, a_t4_n;
  logic [29:0]       fr_t1_o, fr_t1_n, fr_t2_o, fr_t2_n;
  logic [TI_W-1:0]   ix_t1_o, ix_t1_n;
  logic [TV_W-1:0]   lo_o, hi_o, lo_n, hi_n;
  logic              gu_o, gu_n;
  logic [TV_W-1:0]   gd_o, gd_n;
  logic [61:0]       pr_t3_o, pr_t3_n;
  logic [TV_W-1:0]   lo_t3_o, lo_t3_n;
  logic              gu_t3_o, gu_t3_n;
  logic [TV_W-1:0]   g_t4_o, g_t4_n;
  logic              tbl_we;

  // second divider and correction
  lane_a_t           d2a_out;
  lane_b_t           d2b_out;
  logic              v2a, v2b;
  logic [65:0]       q2_o, q2_n;
  logic              v_f;
  txdc_pkg::carry_t  c_f, c_c1, c_c2, c_c3, c_c4, c_m;
  logic [63:0]       f_o, f_n;
  logic              v_c1, v_c2, v_c3, v_c4;
  logic [63:0]       df_c1, fa_c1, fa_c2, fa_c3, fa_c4;
  logic              up_c1, up_c2, up_c3, up_c4;
  logic [79:0]       pl_c2, ph_c2;
  logic [111:0]      n_c3, n_c4;
  logic              clamp_c4, fz_c4;
  d3_t               d3_in, d3_out;
  logic              v3d;
  logic [49:0]       q3;
  logic              v_m;
  logic              up_m;
  logic [49:0]       mag_m;

  // output register
  logic              res_valid;
  txdc_pkg::result_t res_data;
  logic [50:0]       sum_tot, sum_el;

  // whole pipeline moves when the output register can take a new value
  assign adv          = !res_valid || results.ready;
  assign points.ready = adv;
  assign results.valid = res_valid;
  assign results.data  = res_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      old_temp    <= '0;
      new_temp    <= '0;
      atom_weight <= 32'h0001_0000;
    end else if (cfg_we) begin
      case (cfg_index)
        txdc_pkg::REG_OLD_TEMP:    old_temp    <= cfg_data;
        txdc_pkg::REG_NEW_TEMP:    new_temp    <= cfg_data;
        txdc_pkg::REG_ATOM_WEIGHT: atom_weight <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // temp_diff registers, then skip_all and cutoff, before any item needs them
  always_ff @(posedge clk) begin
    temp_diff <= (old_temp > new_temp) ? old_temp - new_temp : new_temp - old_temp;
    // diff <= new/100 is the same as 100*diff <= new
    skip_all  <= (71'(temp_diff) * 71'd100) <= 71'(new_temp);
    cutoff    <= 73'(temp_diff) * 73'd500;
  end

  // s0: input register, s1: partial products of energy*weight, s2: sum
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v0 <= points.valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pt0   <= points.data;
      pt1   <= pt0;
      p_hi1 <= 64'(pt0.energy[63:32]) * 64'(atom_weight);
      p_lo1 <= 64'(pt0.energy[31:0]) * 64'(atom_weight);
      pt2   <= pt1;
      num2  <= {p_hi1, 32'b0} + 96'(p_lo1);
    end
  end

  // s3: pick the branch per temperature and set up the first divider
  // high a: (t<<47)/num gives f-1; low a: (num<<44)/t gives a^2
  assign big_o = num2 >= 96'({old_temp, 18'b0});
  assign big_n = num2 >= 96'({new_temp, 18'b0});

  always_ff @(posedge clk) begin
    if (adv) begin
      dn3_o <= big_o ? 128'({old_temp, 47'b0}) : 128'({num2, 44'b0});
      dd3_o <= big_o ? num2 : 96'(old_temp);
      dn3_n <= big_n ? 128'({new_temp, 47'b0}) : 128'({num2, 44'b0});
      dd3_n <= big_n ? num2 : 96'(new_temp);
      d1a_in.c.cmd  <= pt2.cmd;
      d1a_in.c.idx  <= pt2.table_index;
      d1a_in.c.tval <= pt2.table_value;
      d1a_in.c.tot  <= pt2.total_xs;
      d1a_in.c.el   <= pt2.elastic_xs;
      // points above the cutoff energy or under the 1% rule pass unchanged
      d1a_in.c.pass <= skip_all || (num2 > 96'({cutoff, 16'b0}));
      d1a_in.big_o  <= big_o;
      d1a_in.tz_o   <= old_temp == '0;
      d1b_in.big_n  <= big_n;
      d1b_in.tz_n   <= new_temp == '0;
    end
  end

  txdc_div #(.NW(128), .DW(96), .QW(64), .SW($bits(d1a_t))) u_div1_o (
    .clk(clk), .rst(rst), .en(adv), .vin(v3), .num(dn3_o), .den(dd3_o),
    .side_in(d1a_in), .vout(vd_a), .quo(qd_o), .side_out(d1a_out)
  );

  txdc_div #(.NW(128), .DW(96), .QW(64), .SW($bits(d1b_t))) u_div1_n (
    .clk(clk), .rst(rst), .en(adv), .vin(v3), .num(dn3_n), .den(dd3_n),
    .side_in(d1b_in), .vout(vd_b), .quo(qd_n), .side_out(d1b_out)
  );

  // factor already known for zero temperature or the high-a branch
  always_comb begin
    sqa_in.c      = d1a_out.c;
    sqa_in.fpre_o = d1a_out.tz_o ? 64'h1_0000_0000 : 64'h1_0000_0000 + qd_o;
    sqa_in.sel_o  = !(d1a_out.tz_o || d1a_out.big_o);
    sqb_in.fpre_n = d1b_out.tz_n ? 64'h1_0000_0000 : 64'h1_0000_0000 + qd_n;
    sqb_in.sel_n  = !(d1b_out.tz_n || d1b_out.big_n);
  end

  // a^2 is below 2^62 on the low-a branch
  txdc_sqrt #(.RW(31), .SW($bits(lane_a_t))) u_sqrt_o (
    .clk(clk), .rst(rst), .en(adv), .vin(vd_a && vd_b), .x(qd_o[61:0]),
    .side_in(sqa_in), .vout(vs_a), .root(root_o), .side_out(sqa_out)
  );

  txdc_sqrt #(.RW(31), .SW($bits(lane_b_t))) u_sqrt_n (
    .clk(clk), .rst(rst), .en(adv), .vin(vd_a && vd_b), .x(qd_n[61:0]),
    .side_in(sqb_in), .vout(vs_b), .root(root_n), .side_out(sqb_out)
  );

  // zero root counts as one lsb; table step 0.04 is a*25 in q.30
  assign af_o = (root_o == '0) ? 31'd1 : root_o;
  assign af_n = (root_n == '0) ? 31'd1 : root_n;
  assign sc_o = 36'(af_o) * 36'd25;
  assign sc_n = 36'(af_n) * 36'd25;
  assign ix_o = (32'(sc_o[35:30]) > TABLE_ENTRIES - 2) ? TI_W'(TABLE_ENTRIES - 2) : sc_o[35:30];
  assign ix_n = (32'(sc_n[35:30]) > TABLE_ENTRIES - 2) ? TI_W'(TABLE_ENTRIES - 2) : sc_n[35:30];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_t1 <= 1'b0;
      v_t2 <= 1'b0;
      v_t3 <= 1'b0;
      v_t4 <= 1'b0;
    end else if (adv) begin
      v_t1 <= vs_a && vs_b;
      v_t2 <= v_t1;
      v_t3 <= v_t2;
      v_t4 <= v_t3;
    end
  end

  // t1: address stage; loads write the table here, in item order
  assign tbl_we = adv && v_t1 && (la_t1.c.cmd == txdc_pkg::CMD_LOAD);

  txdc_table #(.ENTRIES(TABLE_ENTRIES)) u_table (
    .clk(clk), .en(adv), .we(tbl_we), .waddr(la_t1.c.idx), .wdata(la_t1.c.tval),
    .ridx0(ix_t1_o), .ridx1(ix_t1_n), .lo0(lo_o), .hi0(hi_o), .lo1(lo_n), .hi1(hi_n)
  );

  // t2: interval width times fraction
  assign gu_o = hi_o >= lo_o;
  assign gu_n = hi_n >= lo_n;
  assign gd_o = gu_o ? hi_o - lo_o : lo_o - hi_o;
  assign gd_n = gu_n ? hi_n - lo_n : lo_n - hi_n;

  always_ff @(posedge clk) begin
    if (adv) begin
      la_t1   <= sqa_out;
      lb_t1   <= sqb_out;
      a_t1_o  <= af_o;
      a_t1_n  <= af_n;
      fr_t1_o <= sc_o[29:0];
      fr_t1_n <= sc_n[29:0];
      ix_t1_o <= ix_o;
      ix_t1_n <= ix_n;

      la_t2   <= la_t1;
      lb_t2   <= lb_t1;
      a_t2_o  <= a_t1_o;
      a_t2_n  <= a_t1_n;
      fr_t2_o <= fr_t1_o;
      fr_t2_n <= fr_t1_n;

      la_t3   <= la_t2;
      lb_t3   <= lb_t2;
      a_t3_o  <= a_t2_o;
      a_t3_n  <= a_t2_n;
      pr_t3_o <= 62'(fr_t2_o) * 62'(gd_o);
      pr_t3_n <= 62'(fr_t2_n) * 62'(gd_n);
      lo_t3_o <= lo_o;
      lo_t3_n <= lo_n;
      gu_t3_o <= gu_o;
      gu_t3_n <= gu_n;

      // t4: interpolated G in q4.28
      la_t4   <= la_t3;
      lb_t4   <= lb_t3;
      a_t4_o  <= a_t3_o;
      a_t4_n  <= a_t3_n;
      g_t4_o  <= gu_t3_o ? lo_t3_o + pr_t3_o[61:30] : lo_t3_o - pr_t3_o[61:30];
      g_t4_n  <= gu_t3_n ? lo_t3_n + pr_t3_n[61:30] : lo_t3_n - pr_t3_n[61:30];
    end
  end

  // f = (G<<34)/a in q32.32
  txdc_div #(.NW(67), .DW(31), .QW(66), .SW($bits(lane_a_t))) u_div2_o (
    .clk(clk), .rst(rst), .en(adv), .vin(v_t4), .num(67'({g_t4_o, 34'b0})),
    .den(a_t4_o), .side_in(la_t4), .vout(v2a), .quo(q2_o), .side_out(d2a_out)
  );

  txdc_div #(.NW(67), .DW(31), .QW(66), .SW($bits(lane_b_t))) u_div2_n (
    .clk(clk), .rst(rst), .en(adv), .vin(v_t4), .num(67'({g_t4_n, 34'b0})),
    .den(a_t4_n), .side_in(lb_t4), .vout(v2b), .quo(q2_n), .side_out(d2b_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v_f  <= 1'b0;
      v_c1 <= 1'b0;
      v_c2 <= 1'b0;
      v_c3 <= 1'b0;
      v_c4 <= 1'b0;
    end else if (adv) begin
      v_f  <= v2a && v2b;
      v_c1 <= v_f;
      v_c2 <= v_c1;
      v_c3 <= v_c2;
      v_c4 <= v_c3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // f stage: saturate the low-a factor, or take the precomputed one
      c_f <= d2a_out.c;
      f_o <= !d2a_out.sel_o ? d2a_out.fpre_o :
             (q2_o[65:64] != 2'b00) ? '1 : q2_o[63:0];
      f_n <= !d2b_out.sel_n ? d2b_out.fpre_n :
             (q2_n[65:64] != 2'b00) ? '1 : q2_n[63:0];

      // c1: sign and size of f2-f1
      c_c1  <= c_f;
      up_c1 <= f_n >= f_o;
      df_c1 <= (f_n >= f_o) ? f_n - f_o : f_o - f_n;
      fa_c1 <= f_o;

      // c2: elastic*df as two partial products
      c_c2  <= c_c1;
      up_c2 <= up_c1;
      fa_c2 <= fa_c1;
      pl_c2 <= 80'(c_c1.el) * 80'(df_c1[31:0]);
      ph_c2 <= 80'(c_c1.el) * 80'(df_c1[63:32]);

      // c3: full product
      c_c3  <= c_c2;
      up_c3 <= up_c2;
      fa_c3 <= fa_c2;
      n_c3  <= {ph_c2, 32'b0} + 112'(pl_c2);

      // c4: quotient at or above 2^50 clamps anyway
      c_c4     <= c_c3;
      up_c4    <= up_c3;
      fa_c4    <= fa_c3;
      n_c4     <= n_c3;
      clamp_c4 <= 114'(n_c3) >= {fa_c3, 50'b0};
      fz_c4    <= fa_c3 == '0;
    end
  end

  always_comb begin
    d3_in.c     = c_c4;
    d3_in.up    = up_c4;
    d3_in.clamp = clamp_c4;
    d3_in.fz    = fz_c4;
  end

  txdc_div #(.NW(112), .DW(64), .QW(50), .SW($bits(d3_t))) u_div3 (
    .clk(clk), .rst(rst), .en(adv), .vin(v_c4), .num(n_c4), .den(fa_c4),
    .side_in(d3_in), .vout(v3d), .quo(q3), .side_out(d3_out)
  );

  // m: correction magnitude, zero when f1 is zero, capped at 2^49
  always_ff @(posedge clk) begin
    if (rst) begin
      v_m <= 1'b0;
    end else if (adv) begin
      v_m <= v3d;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_m   <= d3_out.c;
      up_m  <= d3_out.up;
      mag_m <= d3_out.fz ? '0 :
               (d3_out.clamp || q3 > 50'h2_0000_0000_0000) ? 50'h2_0000_0000_0000 : q3;
    end
  end

  // saturating update of both cross sections
  assign sum_tot = 51'(c_m.tot) + 51'(mag_m);
  assign sum_el  = 51'(c_m.el) + 51'(mag_m);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= v_m && (c_m.cmd == txdc_pkg::CMD_CORRECT);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (c_m.pass) begin
        res_data.total_xs_out   <= c_m.tot;
        res_data.elastic_xs_out <= c_m.el;
        res_data.adjusted       <= 1'b0;
      end else if (up_m) begin
        res_data.total_xs_out   <= (sum_tot > 51'({XS_W{1'b1}})) ? '1 : sum_tot[XS_W-1:0];
        res_data.elastic_xs_out <= (sum_el > 51'({XS_W{1'b1}})) ? '1 : sum_el[XS_W-1:0];
        res_data.adjusted       <= 1'b1;
      end else begin
        res_data.total_xs_out   <= (50'(c_m.tot) > mag_m) ? XS_W'(50'(c_m.tot) - mag_m) : '0;
        res_data.elastic_xs_out <= (50'(c_m.el) > mag_m) ? XS_W'(50'(c_m.el) - mag_m) : '0;
        res_data.adjusted       <= 1'b1;
      end
    end
  end

endmodule
